FILE: rtl/core/assert_macros.svh
// assertion helpers for the step counter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked at every clock edge, also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: rtl/core/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// types, constants and codes shared by the step counter files
// ----------------------------------------------------------------------------
package asc_pkg;
  localparam int unsigned NewtonIterationsDef = 16;
  localparam int unsigned AxisW  = 10;
  localparam int unsigned MagW   = 11;
  localparam int unsigned SumW   = 22;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgWeight    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDwell     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOvershoot = 2'd2;

  localparam logic [9:0] WeightReset    = 10'd128;
  localparam logic [7:0] DwellReset     = 8'd5;
  localparam logic [9:0] OvershootReset = 10'd25;
  localparam logic [10:0] ValleyReset   = 11'd1024;

  typedef enum logic [1:0] {
    PhSeekMax   = 2'd0,
    PhSeekDown  = 2'd1,
    PhSeekMin   = 2'd2,
    PhSeekUp    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StIdle, StSquare, StDivStart, StDivWait, StUpdate, StOut
  } ctrl_state_e;

  typedef struct packed {
    logic load;       // capture sample
    logic square;     // form sum of squares and seed
    logic div_start;  // start one newton division
    logic div_step;   // finish newton step
    logic update;     // moving average and phase machine
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic est_zero;
  } dp_stat_t;
endpackage

FILE: rtl/core/asc_if.sv
// ----------------------------------------------------------------------------
// asc_sample_if / asc_result_if
// valid/ready channels for samples and results
// ----------------------------------------------------------------------------
interface asc_sample_if;
  logic valid;
  logic ready;
  logic [9:0] accel_x;
  logic [9:0] accel_y;
  logic [9:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface asc_result_if;
  logic valid;
  logic ready;
  logic [10:0] magnitude;
  logic [10:0] average;
  logic [31:0] step_count;
  logic [1:0]  phase;
  logic        step_pulse;
  modport source (output valid, magnitude, average, step_count, phase, step_pulse,
                  input ready);
  modport sink   (input valid, magnitude, average, step_count, phase, step_pulse,
                  output ready);
endinterface

FILE: rtl/core/accel_step_counter_top.sv
// ----------------------------------------------------------------------------
// accel_step_counter_top
// peak/valley pedometer on three-axis accelerometer samples
// ----------------------------------------------------------------------------
// One sample at a time: a sample beat is taken in idle, the three squares
// are summed, then each of NewtonIterations newton steps divides the sum
// by the estimate in the shared restoring divider, the average and phase
// update follow and the result beat is shown until taken. The next sample
// beat is taken only once the result beat is taken. A zero estimate ends
// the loop after the first step.
module accel_step_counter_top #(
  parameter int unsigned NewtonIterations = asc_pkg::NewtonIterationsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  asc_sample_if.sink  in_if,
  asc_result_if.source out_if,
  input  logic        cfg_we_i,
  input  logic [asc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [asc_pkg::CfgDataW-1:0] cfg_data_i
);
  import asc_pkg::*;
`include "assert_macros.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  asc_ctrl #(.NewtonIterations(NewtonIterations)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // arithmetic and step state
  asc_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .accel_x_i    (in_if.accel_x),
    .accel_y_i    (in_if.accel_y),
    .accel_z_i    (in_if.accel_z),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .magnitude_o  (out_if.magnitude),
    .average_o    (out_if.average),
    .step_count_o (out_if.step_count),
    .phase_o      (out_if.phase),
    .step_pulse_o (out_if.step_pulse)
  );

  // a sample beat is never taken while a result waits
  `ASSERT_CLK(a_no_overlap, clk_i, rst_ni, !(in_if.ready && out_if.valid), "ready with result")
  // the update command is always followed by a result beat
  `ASSERT_CLK(a_upd_then_out, clk_i, rst_ni, cmd.update |=> out_if.valid, "no result after update")
  // a step pulse comes with a changed count
  `ASSERT_CLK(a_pulse_count, clk_i, rst_ni, ($rose(out_if.valid) && out_if.step_pulse) |-> (out_if.step_count != $past(out_if.step_count)), "pulse without count")
endmodule

FILE: rtl/core/asc_divider.sv
// ----------------------------------------------------------------------------
// asc_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module asc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [21:0] dividend_i,
  input  logic [22:0] divisor_i,
  output logic [21:0] quotient_o,
  output logic        done_o
);
  import asc_pkg::*;
  localparam int unsigned NW = 22;
  localparam int unsigned VW = 23;

  logic [NW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [VW:0]   trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      quo_d = dividend_i; rem_d = '0; dvs_d = divisor_i;
      cnt_d = 5'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NW-1]} - {1'b0, dvs_q};
      if (!trial[VW]) begin
        rem_d = trial[VW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[VW-2:0], quo_q[NW-1]};
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;
endmodule

FILE: rtl/core/asc_datapath.sv
// ----------------------------------------------------------------------------
// asc_datapath
// sum of squares, newton root, moving average and phase machine
// ----------------------------------------------------------------------------
module asc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  asc_pkg::dp_cmd_t  cmd_i,
  output asc_pkg::dp_stat_t stat_o,
  input  logic [9:0]        accel_x_i,
  input  logic [9:0]        accel_y_i,
  input  logic [9:0]        accel_z_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [9:0]        cfg_data_i,
  output logic [10:0]       magnitude_o,
  output logic [10:0]       average_o,
  output logic [31:0]       step_count_o,
  output logic [1:0]        phase_o,
  output logic              step_pulse_o
);
  import asc_pkg::*;

  logic [9:0]  ax_q, ay_q, az_q;
  logic [1:0]  sq_sel_q;
  logic [SumW-1:0] s_q;
  logic [22:0] t_q;          // estimate, seeded with s/16+1
  logic [19:0] sqr;
  logic [9:0]  sq_op;
  logic [21:0] quo;
  logic        div_done;

  logic [9:0]  weight_q;
  logic [7:0]  dwell_tgt_q;
  logic [9:0]  over_q;

  logic        seeded_q;
  logic [10:0] avg_q, peak_q, valley_q, mag_q;
  logic [7:0]  dwell_q;
  phase_e      phase_q;
  logic [31:0] steps_q;
  logic        pulse_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WeightReset; dwell_tgt_q <= DwellReset; over_q <= OvershootReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWeight:    weight_q    <= cfg_data_i;
        CfgDwell:     dwell_tgt_q <= cfg_data_i[7:0];
        CfgOvershoot: over_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // squares one axis a cycle under the square command, x then y then z
  always_comb begin
    case (sq_sel_q)
      2'd0:    sq_op = ax_q;
      2'd1:    sq_op = ay_q;
      default: sq_op = az_q;
    endcase
  end
  assign sqr = sq_op * sq_op;

  // (t*t+s)/t floored is t + s/t, so only the sum is divided by t
  asc_divider u_div (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (s_q),
    .divisor_i  (t_q),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign stat_o.div_done = div_done;
  assign stat_o.est_zero = (t_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= accel_x_i; ay_q <= accel_y_i; az_q <= accel_z_i;
      s_q <= '0; sq_sel_q <= 2'd0;
    end else if (cmd_i.square) begin
      s_q <= s_q + SumW'(sqr);
      sq_sel_q <= sq_sel_q + 2'd1;
      t_q <= 23'((s_q + SumW'(sqr)) >> 4) + 23'd1;
    end else if (cmd_i.div_step) begin
      t_q <= 23'((24'(t_q) + 24'(quo)) >> 1);
    end
  end

  // average and phase machine
  logic [10:0] mag_w, avg_new;
  logic [20:0] prod_a, prod_b;
  logic [21:0] avg_sum;
  logic [11:0] mag_plus, avg_plus;
  logic [7:0]  dwell_inc;

  assign mag_w    = (t_q > 23'd2047) ? 11'd2047 : t_q[10:0];
  assign prod_a   = weight_q * mag_w;
  assign prod_b   = (10'd1023 - weight_q) * avg_q;
  assign avg_sum  = 22'(prod_a) + 22'(prod_b);
  assign avg_new  = avg_sum[20:10];
  assign mag_plus = 12'(mag_w) + 12'(over_q);
  assign avg_plus = 12'(avg_new) + 12'(over_q);
  assign dwell_inc = (dwell_q == 8'd255) ? dwell_q : dwell_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0; avg_q <= '0; phase_q <= PhSeekMax; peak_q <= '0;
      valley_q <= ValleyReset; dwell_q <= '0; steps_q <= '0; pulse_q <= 1'b0;
      mag_q <= '0;
    end else if (cmd_i.update) begin
      mag_q <= mag_w;
      pulse_q <= 1'b0;
      if (!seeded_q) begin
        seeded_q <= 1'b1; avg_q <= mag_w;
      end else begin
        avg_q <= avg_new;
        unique case (phase_q)
          PhSeekMax: begin
            if (mag_w > peak_q) begin
              peak_q <= mag_w; dwell_q <= '0;
            end else begin
              dwell_q <= dwell_inc;
              if (dwell_inc >= dwell_tgt_q) phase_q <= PhSeekDown;
            end
          end
          PhSeekDown: begin
            if (mag_w > peak_q) begin
              peak_q <= mag_w; dwell_q <= '0; phase_q <= PhSeekMax;
            end else if (mag_plus < 12'(avg_new)) begin
              steps_q <= steps_q + 32'd1; pulse_q <= 1'b1;
              valley_q <= ValleyReset; dwell_q <= '0; phase_q <= PhSeekMin;
            end
          end
          PhSeekMin: begin
            if (mag_w < valley_q) begin
              valley_q <= mag_w; dwell_q <= '0;
            end else begin
              dwell_q <= dwell_inc;
              if (dwell_inc >= dwell_tgt_q) phase_q <= PhSeekUp;
            end
          end
          default: begin
            if (mag_w < valley_q) begin
              valley_q <= mag_w; dwell_q <= '0; phase_q <= PhSeekMin;
            end else if (12'(mag_w) > avg_plus) begin
              steps_q <= steps_q + 32'd1; pulse_q <= 1'b1;
              peak_q <= '0; dwell_q <= '0; phase_q <= PhSeekMax;
            end
          end
        endcase
      end
    end
  end

  assign magnitude_o  = mag_q;
  assign average_o    = avg_q;
  assign step_count_o = steps_q;
  assign phase_o      = phase_q;
  assign step_pulse_o = pulse_q;
endmodule

FILE: rtl/core/asc_ctrl.sv
// ----------------------------------------------------------------------------
// asc_ctrl
// sequencer for one sample: squares, newton loop, update, result beat
// ----------------------------------------------------------------------------
module asc_ctrl #(
  parameter int unsigned NewtonIterations = asc_pkg::NewtonIterationsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output asc_pkg::dp_cmd_t  cmd_o,
  input  asc_pkg::dp_stat_t stat_i
);
  import asc_pkg::*;
  localparam int unsigned ItW = $clog2(NewtonIterations + 1);

  ctrl_state_e state_q, state_d;
  logic [ItW-1:0] it_q, it_d;
  logic [1:0] sq_q, sq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; it_q <= '0; sq_q <= '0;
    end else begin
      state_q <= state_d; it_q <= it_d; sq_q <= sq_d;
    end
  end

  always_comb begin
    state_d = state_q; it_d = it_q; sq_d = sq_q;
    cmd_o = '0;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1; sq_d = '0; state_d = StSquare;
        end
      end
      StSquare: begin
        cmd_o.square = 1'b1;
        sq_d = sq_q + 2'd1;
        if (sq_q == 2'd2) begin
          it_d = '0; state_d = StDivStart;
        end
      end
      StDivStart: begin
        if (stat_i.est_zero || it_q == ItW'(NewtonIterations)) begin
          state_d = StUpdate;
        end else begin
          cmd_o.div_start = 1'b1; state_d = StDivWait;
        end
      end
      StDivWait: begin
        if (stat_i.div_done) begin
          cmd_o.div_step = 1'b1; it_d = it_q + ItW'(1); state_d = StDivStart;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1; state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the accelerometer step counter: an in-bench model
// predicts every result beat from the accepted sample beats, a monitor
// compares them field by field under random idling on both channels
// ----------------------------------------------------------------------------
module testbench;
  import asc_pkg::*;

  localparam int unsigned DrainCycles = 500;     // a little over one sample time
  localparam longint unsigned CycleLimit = 6000000;

  // one expected result beat
  typedef struct {
    logic [10:0] magnitude;
    logic [10:0] average;
    logic [31:0] step_count;
    phase_e      phase;
    logic        step_pulse;
  } step_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgWeight;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  asc_sample_if in_if ();
  asc_result_if out_if ();

  accel_step_counter_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if.sink),
    .out_if     (out_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // model copy of the configuration
  logic [9:0] weight_q;
  logic [7:0] dwell_tgt_q;
  logic [9:0] margin_q;
  // model copy of the tracking state
  logic        seeded_q;
  logic [10:0] avg_q;
  phase_e      phase_q;
  logic [10:0] peak_q;
  logic [10:0] valley_q;
  logic [7:0]  dwell_q;
  logic [31:0] steps_q;

  step_result_t pending_results[$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  bit idle_en = 1'b1;        // random gaps on both channels
  int unsigned hold_left = 0; // long receiver hold-off, counted by the receiver

  // newton square root, exact in 64 bits, saturated to the magnitude width
  function automatic logic [10:0] newton_root(logic [63:0] s);
    logic [63:0] t;
    t = s / 16 + 1;
    for (int i = 0; i < NewtonIterationsDef; i++) begin
      if (t == 0) break;
      t = ((t * t + s) / t) / 2;
    end
    if (t > 2047) t = 2047;
    return t[10:0];
  endfunction

  // confirm a local extreme once enough samples pass without a new one
  function automatic void dwell_tick(phase_e nxt);
    if (dwell_q != 8'd255) dwell_q++;
    if (dwell_q >= dwell_tgt_q) phase_q = nxt;
  endfunction

  // advance the pedometer model by one sample and queue its result
  function automatic void track_sample(logic [9:0] x, logic [9:0] y, logic [9:0] z);
    step_result_t r;
    logic [63:0] s;
    logic [31:0] acc;
    logic [10:0] mag;
    s = 64'(x) * x + 64'(y) * y + 64'(z) * z;
    mag = newton_root(s);
    r.step_pulse = 1'b0;
    if (!seeded_q) begin
      // first sample only seeds the average
      seeded_q = 1'b1;
      avg_q = mag;
    end else begin
      acc = 32'(weight_q) * mag + (32'd1023 - weight_q) * avg_q;
      avg_q = acc[20:10];
      case (phase_q)
        PhSeekMax: begin
          if (mag > peak_q) begin
            peak_q = mag;
            dwell_q = '0;
          end else dwell_tick(PhSeekDown);
        end
        PhSeekDown: begin
          if (mag > peak_q) begin
            peak_q = mag;
            dwell_q = '0;
            phase_q = PhSeekMax;
          end else if (32'(mag) + margin_q < 32'(avg_q)) begin
            steps_q++;
            r.step_pulse = 1'b1;
            valley_q = ValleyReset;
            dwell_q = '0;
            phase_q = PhSeekMin;
          end
        end
        PhSeekMin: begin
          if (mag < valley_q) begin
            valley_q = mag;
            dwell_q = '0;
          end else dwell_tick(PhSeekUp);
        end
        default: begin
          if (mag < valley_q) begin
            valley_q = mag;
            dwell_q = '0;
            phase_q = PhSeekMin;
          end else if (32'(mag) > 32'(avg_q) + margin_q) begin
            steps_q++;
            r.step_pulse = 1'b1;
            peak_q = '0;
            dwell_q = '0;
            phase_q = PhSeekMax;
          end
        end
      endcase
    end
    r.magnitude = mag;
    r.average = avg_q;
    r.step_count = steps_q;
    r.phase = phase_q;
    pending_results.push_back(r);
  endfunction

  // drive one sample beat; valid stays high into the next beat unless a gap comes
  task automatic send_sample(logic [9:0] x, logic [9:0] y, logic [9:0] z);
    if (idle_en && $urandom_range(99) < 19) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.accel_x <= x;
    in_if.accel_y <= y;
    in_if.accel_z <= z;
    do @(posedge clk_i); while (!in_if.ready);
    track_sample(x, y, z);
    @(negedge clk_i);
  endtask

  // let every queued result arrive, then allow the block to settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgWeight:    weight_q = data;
      CfgDwell:     dwell_tgt_q = data[7:0];
      CfgOvershoot: margin_q = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [9:0] w, logic [7:0] d, logic [9:0] m);
    write_reg(CfgWeight, w);
    write_reg(CfgDwell, {2'b00, d});
    write_reg(CfgOvershoot, m);
  endtask

  // gait-like sequence: magnitude swings in a triangle around a center,
  // with a share of noise samples and broken swings
  task automatic walk_samples(int unsigned n);
    int unsigned per, k, amp, ctr, lvl;
    per = $urandom_range(4, 30);
    amp = $urandom_range(20, 500);
    ctr = $urandom_range(amp, 1023 - amp / 2);
    k = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        send_sample(10'($urandom), 10'($urandom), 10'($urandom));
      end else begin
        lvl = (k < per) ? ctr - amp + 2 * amp * k / per
                        : ctr + amp - 2 * amp * (k - per) / per;
        if (lvl > 1023) lvl = 1023;
        send_sample(10'($urandom_range(15)), 10'($urandom_range(15)), lvl[9:0]);
      end
      k = (k + 1) % (2 * per);
      if (k == 0 && $urandom_range(9) == 0) begin
        per = $urandom_range(4, 30);
        amp = $urandom_range(20, 500);
        ctr = $urandom_range(amp, 1023 - amp / 2);
      end
    end
  endtask

  // field extremes, zero root, seeding sample, single bits per axis
  task automatic test_directed();
    send_sample(10'd0, 10'd0, 10'd0);          // seeding sample with zero root
    send_sample(10'h3FF, 10'h3FF, 10'h3FF);
    send_sample(10'd0, 10'd0, 10'd0);
    send_sample(10'd1, 10'd0, 10'd0);
    for (int b = 0; b < 10; b++) send_sample(10'(1 << b), 10'(1 << (9 - b)), 10'h3FF ^ 10'(1 << b));
    send_sample(10'h3FF, 10'd0, 10'd0);
    send_sample(10'd0, 10'h3FF, 10'd0);
    send_sample(10'd0, 10'd0, 10'h3FF);
    send_sample(10'h155, 10'h2AA, 10'h155);
    drain_results();
  endtask

  // sweep the registers through their extremes with gait traffic
  task automatic test_config_sweep();
    set_config(10'd0, 8'd1, 10'd0);      walk_samples(60);  drain_results();
    set_config(10'd1023, 8'd255, 10'd1023); walk_samples(40); drain_results();
    set_config(10'd512, 8'd0, 10'd0);    walk_samples(60);  drain_results();
    set_config(10'd1023, 8'd1, 10'd1);   walk_samples(60);  drain_results();
    set_config(10'd128, 8'd5, 10'd25);   walk_samples(60);  drain_results();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering samples
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_left = 3000;
    @(negedge clk_i);
    walk_samples(20);
    drain_results();
  endtask

  // long random run, first with no idling at all, then with idling
  task automatic test_random();
    idle_en = 1'b0;
    walk_samples(200);
    drain_results();
    idle_en = 1'b1;
    set_config(10'($urandom), 8'($urandom_range(1, 12)), 10'($urandom_range(60)));
    walk_samples(500);
    drain_results();
    set_config(10'($urandom), 8'($urandom_range(1, 6)), 10'($urandom_range(20)));
    walk_samples(450);
    drain_results();
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= !(idle_en && $urandom_range(99) < 19);
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    step_result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got mag %0d avg %0d", $time,
                 out_if.magnitude, out_if.average);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_if.magnitude !== e.magnitude) begin
          $display("%0t: magnitude exp %0d got %0d", $time, e.magnitude, out_if.magnitude);
          errors++;
        end
        if (out_if.average !== e.average) begin
          $display("%0t: average exp %0d got %0d", $time, e.average, out_if.average);
          errors++;
        end
        if (out_if.step_count !== e.step_count) begin
          $display("%0t: step_count exp %0d got %0d", $time, e.step_count,
                   out_if.step_count);
          errors++;
        end
        if (out_if.phase !== e.phase) begin
          $display("%0t: phase exp %0d got %0d", $time, e.phase, out_if.phase);
          errors++;
        end
        if (out_if.step_pulse !== e.step_pulse) begin
          $display("%0t: step_pulse exp %0d got %0d", $time, e.step_pulse,
                   out_if.step_pulse);
          errors++;
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    out_if.ready = 1'b0;
    // reset values of the model
    weight_q = WeightReset;
    dwell_tgt_q = DwellReset;
    margin_q = OvershootReset;
    seeded_q = 1'b0;
    avg_q = '0;
    phase_q = PhSeekMax;
    peak_q = '0;
    valley_q = ValleyReset;
    dwell_q = '0;
    steps_q = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/asc_pkg.sv
rtl/core/asc_if.sv
rtl/core/asc_divider.sv
rtl/core/asc_datapath.sv
rtl/core/asc_ctrl.sv
rtl/core/accel_step_counter_top.sv
tb/sv/testbench.sv
